FILE: rtl/core/sparse_set_engine_unit_macros.svh
// assertion macros for the sparse set engine
// clocked on aclk, disabled while aresetn is low; no other dependencies
`ifndef SPARSE_SET_ENGINE_UNIT_MACROS_SVH
`define SPARSE_SET_ENGINE_UNIT_MACROS_SVH

// same-cycle implication
`define SSE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SSE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/sse_pkg.sv
// shared types and constants for the sparse set engine
// no dependencies; used by sparse_set_engine_unit
`default_nettype none

package sse_pkg;

    // handle and set geometry
    localparam int IDX_W    = 10;
    localparam int GEN_W    = 8;
    localparam int ENT_W    = IDX_W + GEN_W;
    localparam int CAPACITY = 1024;
    localparam int POS_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int OP_W     = 3;

    // sparse map entry: valid bit over dense position
    localparam int MAP_W     = 1 + POS_W;
    localparam int MAP_DEPTH = 1 << IDX_W;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT          = 3'd0,
        OP_REMOVE          = 3'd1,
        OP_CONTAINS        = 3'd2,
        OP_CONTAINS_BEFORE = 3'd3,
        OP_SWAP            = 3'd4,
        OP_CLEAR           = 3'd5,
        OP_READ_DENSE      = 3'd6
    } op_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_REM_FIX,
        ST_SWAP_B,
        ST_SWAP_C,
        ST_CLEAR,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [ENT_W-1:0] entity;
        logic [POS_W-1:0] pos_a;
        logic [POS_W-1:0] pos_b;
        logic [CNT_W-1:0] limit;
    } in_beat_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
        logic [ENT_W-1:0] entity_out;
        logic [CNT_W-1:0] count;
        logic             error;
    } out_beat_t;

endpackage

`default_nettype wire

FILE: rtl/core/sparse_set_engine_unit.sv
// sparse set engine: sparse map and dense list in two synchronous memories
// depends on sse_pkg and sparse_set_engine_unit_macros.svh
`default_nettype none
// Usage
//   s_valid/s_ready/s_data carry one operation beat (op, entity, pos_a, pos_b, limit).
//   m_valid/m_ready/m_data carry exactly one result beat per operation, in order:
//   found, position, entity_out, count (after the operation) and error.
//   One operation is worked at a time by a sequencer around two single-port-write,
//   one-read memories with registered read data.
// Steps per operation
//   insert, contains, contains_before, read_dense, unused op, remove of a
//   non-member, swap out of range: decided in EXEC, then DONE
//   remove of a member: a second map write clears the removed index after the move
//   swap in range: the one dense read port fetches both handles in turn
//   clear: one map invalidate per listed handle
// Reset
//   aresetn low clears the count and control; afterwards a clearing pass writes
//   all 1024 sparse map entries to invalid, one per cycle, with s_ready low.
// Stalls
//   a finished result sits in the output register until taken; the next beat may be
//   accepted meanwhile, but a second result waits in the sequencer until it frees.

module sparse_set_engine_unit (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire sse_pkg::in_beat_t  s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output sse_pkg::out_beat_t      m_data
);

    `include "sparse_set_engine_unit_macros.svh"

    localparam int IDX_W = sse_pkg::IDX_W;
    localparam int ENT_W = sse_pkg::ENT_W;
    localparam int POS_W = sse_pkg::POS_W;
    localparam int CNT_W = sse_pkg::CNT_W;
    localparam int MAP_W = sse_pkg::MAP_W;

    // memories
    logic [MAP_W-1:0] map_mem   [sse_pkg::MAP_DEPTH];
    logic [ENT_W-1:0] dense_mem [sse_pkg::CAPACITY];

    logic             map_we;
    logic [IDX_W-1:0] map_wa;
    logic [MAP_W-1:0] map_wd;
    logic [IDX_W-1:0] map_ra;
    logic [MAP_W-1:0] map_rd_data_reg;

    logic             dense_we;
    logic [POS_W-1:0] dense_wa;
    logic [ENT_W-1:0] dense_wd;
    logic [POS_W-1:0] dense_ra;
    logic [ENT_W-1:0] dense_rd_data_reg;

    // control and payload registers
    sse_pkg::state_t    state_reg, state_next;
    sse_pkg::in_beat_t  req_reg, req_next;
    sse_pkg::out_beat_t res_reg, res_next;
    sse_pkg::out_beat_t m_data_reg, m_data_next;
    logic               m_valid_reg, m_valid_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   init_idx_reg, init_idx_next;
    logic [CNT_W-1:0]   clr_idx_reg, clr_idx_next;
    logic [ENT_W-1:0]   ha_reg, ha_next;

    // helpers
    logic             map_hit;
    logic [POS_W-1:0] map_pos;
    logic [CNT_W-1:0] cnt_m1;
    logic [CNT_W-1:0] clr_idx_inc;
    logic             clr_last;
    logic             clr_finish;
    logic             ins_commit;
    logic             out_free;
    logic             pa_bad;
    logic             pb_bad;

    assign map_hit     = map_rd_data_reg[MAP_W-1];
    assign map_pos     = map_rd_data_reg[POS_W-1:0];
    assign cnt_m1      = count_reg - 1'b1;
    assign clr_idx_inc = clr_idx_reg + 1'b1;
    assign clr_last    = (clr_idx_inc == count_reg);
    assign out_free    = !m_valid_reg || m_ready;
    assign pa_bad      = ({1'b0, req_reg.pos_a} >= count_reg);
    assign pb_bad      = ({1'b0, req_reg.pos_b} >= count_reg);

    // sparse map memory
    always_ff @(posedge aclk) begin
        if (map_we) begin
            map_mem[map_wa] <= map_wd;
        end
        map_rd_data_reg <= map_mem[map_ra];
    end

    // dense list memory
    always_ff @(posedge aclk) begin
        if (dense_we) begin
            dense_mem[dense_wa] <= dense_wd;
        end
        dense_rd_data_reg <= dense_mem[dense_ra];
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= sse_pkg::ST_INIT;
            m_valid_reg  <= 1'b0;
            count_reg    <= '0;
            init_idx_reg <= '0;
        end else begin
            state_reg    <= state_next;
            m_valid_reg  <= m_valid_next;
            count_reg    <= count_next;
            init_idx_reg <= init_idx_next;
        end
    end

    // payload state
    always_ff @(posedge aclk) begin
        req_reg     <= req_next;
        res_reg     <= res_next;
        m_data_reg  <= m_data_next;
        clr_idx_reg <= clr_idx_next;
        ha_reg      <= ha_next;
    end

    // sequencer
    always_comb begin
        state_next    = state_reg;
        req_next      = req_reg;
        res_next      = res_reg;
        m_data_next   = m_data_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        count_next    = count_reg;
        init_idx_next = init_idx_reg;
        clr_idx_next  = clr_idx_reg;
        ha_next       = ha_reg;
        s_ready       = 1'b0;
        map_we        = 1'b0;
        map_wa        = req_reg.entity[IDX_W-1:0];
        map_wd        = '0;
        map_ra        = s_data.entity[IDX_W-1:0];
        dense_we      = 1'b0;
        dense_wa      = req_reg.pos_a;
        dense_wd      = req_reg.entity;
        dense_ra      = s_data.pos_a;
        clr_finish    = 1'b0;
        ins_commit    = 1'b0;

        case (state_reg)
            // invalidate every map entry after reset
            sse_pkg::ST_INIT: begin
                map_we        = 1'b1;
                map_wa        = init_idx_reg;
                map_wd        = '0;
                init_idx_next = init_idx_reg + 1'b1;
                if (init_idx_reg == {IDX_W{1'b1}}) begin
                    state_next = sse_pkg::ST_IDLE;
                end
            end

            // take a beat and start its first reads
            sse_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                case (s_data.op)
                    sse_pkg::OP_REMOVE:                   dense_ra = cnt_m1[POS_W-1:0];
                    sse_pkg::OP_SWAP, sse_pkg::OP_READ_DENSE: dense_ra = s_data.pos_a;
                    default:                              dense_ra = '0;
                endcase
                if (s_valid) begin
                    req_next     = s_data;
                    res_next     = '0;
                    clr_idx_next = '0;
                    state_next   = sse_pkg::ST_EXEC;
                end
            end

            // first read data is back
            sse_pkg::ST_EXEC: begin
                state_next = sse_pkg::ST_DONE;
                case (req_reg.op)
                    sse_pkg::OP_INSERT: begin
                        if (map_hit) begin
                            res_next.error    = 1'b1;
                            res_next.position = map_pos;
                        end else if (count_reg == CNT_W'(sse_pkg::CAPACITY)) begin
                            res_next.error = 1'b1;
                        end else begin
                            ins_commit        = 1'b1;
                            map_we            = 1'b1;
                            map_wd            = {1'b1, count_reg[POS_W-1:0]};
                            dense_we          = 1'b1;
                            dense_wa          = count_reg[POS_W-1:0];
                            dense_wd          = req_reg.entity;
                            res_next.position = count_reg[POS_W-1:0];
                            count_next        = count_reg + 1'b1;
                        end
                    end
                    sse_pkg::OP_REMOVE: begin
                        // move the last handle into the hole
                        if (map_hit) begin
                            dense_we          = 1'b1;
                            dense_wa          = map_pos;
                            dense_wd          = dense_rd_data_reg;
                            map_we            = 1'b1;
                            map_wa            = dense_rd_data_reg[IDX_W-1:0];
                            map_wd            = {1'b1, map_pos};
                            res_next.position = map_pos;
                            state_next        = sse_pkg::ST_REM_FIX;
                        end
                    end
                    sse_pkg::OP_CONTAINS: begin
                        if (map_hit) begin
                            res_next.found    = 1'b1;
                            res_next.position = map_pos;
                        end
                    end
                    sse_pkg::OP_CONTAINS_BEFORE: begin
                        if (map_hit) begin
                            res_next.position = map_pos;
                            res_next.found    = ({1'b0, map_pos} < req_reg.limit);
                        end
                    end
                    sse_pkg::OP_SWAP: begin
                        if (pa_bad || pb_bad) begin
                            res_next.error = 1'b1;
                        end else begin
                            ha_next    = dense_rd_data_reg;
                            dense_ra   = req_reg.pos_b;
                            state_next = sse_pkg::ST_SWAP_B;
                        end
                    end
                    sse_pkg::OP_CLEAR: begin
                        // position zero is already read back
                        if (count_reg == '0) begin
                            clr_finish = 1'b1;
                        end else begin
                            map_we = 1'b1;
                            map_wa = dense_rd_data_reg[IDX_W-1:0];
                            map_wd = '0;
                            if (clr_last) begin
                                clr_finish = 1'b1;
                                count_next = '0;
                            end else begin
                                dense_ra     = clr_idx_inc[POS_W-1:0];
                                clr_idx_next = clr_idx_inc;
                                state_next   = sse_pkg::ST_CLEAR;
                            end
                        end
                    end
                    sse_pkg::OP_READ_DENSE: begin
                        if (pa_bad) begin
                            res_next.error = 1'b1;
                        end else begin
                            res_next.entity_out = dense_rd_data_reg;
                        end
                    end
                    default: begin
                        state_next = sse_pkg::ST_DONE;
                    end
                endcase
            end

            // drop the removed index, after the moved entry was written
            sse_pkg::ST_REM_FIX: begin
                map_we     = 1'b1;
                map_wa     = req_reg.entity[IDX_W-1:0];
                map_wd     = '0;
                count_next = cnt_m1;
                state_next = sse_pkg::ST_DONE;
            end

            // second handle is back: place it at pos_a
            sse_pkg::ST_SWAP_B: begin
                dense_we   = 1'b1;
                dense_wa   = req_reg.pos_a;
                dense_wd   = dense_rd_data_reg;
                map_we     = 1'b1;
                map_wa     = dense_rd_data_reg[IDX_W-1:0];
                map_wd     = {1'b1, req_reg.pos_a};
                state_next = sse_pkg::ST_SWAP_C;
            end

            // first handle goes to pos_b
            sse_pkg::ST_SWAP_C: begin
                dense_we   = 1'b1;
                dense_wa   = req_reg.pos_b;
                dense_wd   = ha_reg;
                map_we     = 1'b1;
                map_wa     = ha_reg[IDX_W-1:0];
                map_wd     = {1'b1, req_reg.pos_b};
                state_next = sse_pkg::ST_DONE;
            end

            // walk the dense list, one invalidate per cycle
            sse_pkg::ST_CLEAR: begin
                map_we = 1'b1;
                map_wa = dense_rd_data_reg[IDX_W-1:0];
                map_wd = '0;
                if (clr_last) begin
                    clr_finish = 1'b1;
                    count_next = '0;
                    state_next = sse_pkg::ST_DONE;
                end else begin
                    dense_ra     = clr_idx_inc[POS_W-1:0];
                    clr_idx_next = clr_idx_inc;
                end
            end

            // hand the result to the output register
            sse_pkg::ST_DONE: begin
                if (out_free) begin
                    m_valid_next      = 1'b1;
                    m_data_next       = res_reg;
                    m_data_next.count = count_reg;
                    state_next        = sse_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = sse_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // checks
    `SSE_ASSERT_IMP(a_init_blocks_input, state_reg == sse_pkg::ST_INIT, !s_ready,
        "beat taken during map clearing pass")
    `SSE_ASSERT_NXT(a_insert_grows_count, ins_commit,
        count_reg == $past(count_reg) + 1'b1, "insert did not grow count")
    `SSE_ASSERT_NXT(a_clear_empties, clr_finish, count_reg == '0,
        "clear left entries counted")
    `SSE_ASSERT_NXT(a_result_count, (state_reg == sse_pkg::ST_DONE) && out_free,
        m_valid_reg && (m_data_reg.count == count_reg), "result beat count mismatch")

endmodule

`default_nettype wire

FILE: test/testbench.sv
// self-checking testbench for sparse_set_engine_unit: directed table, random ops
// depends on sse_pkg and the sparse_set_engine_unit rtl; needs no files or arguments
`default_nettype none

module testbench;
    import sse_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int RANDOM_BEATS = 525;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 12;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_beat_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_beat_t m_data;

    // predicted copy of the set
    logic             slot_live [MAP_DEPTH];
    logic [POS_W-1:0] slot_pos [MAP_DEPTH];
    logic [ENT_W-1:0] packed_handles [CAPACITY];
    int               held;

    out_beat_t pending_results [$];
    int        mismatches = 0;
    int        cycle_count = 0;
    bit        steady = 1'b0;
    bit        hold_request = 1'b0;

    // directed stimulus table
    typedef struct {
        in_beat_t  beat;
        bit        typed;
        out_beat_t result;
    } stim_row_t;
    stim_row_t directed_rows [$];

    sparse_set_engine_unit DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #6 aclk = ~aclk;

    // run time limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("sparse_set_engine_unit test failed");
            $finish;
        end
    end

    // apply one operation to the predicted set and return its result beat
    function automatic out_beat_t apply_set_op(input in_beat_t b);
        out_beat_t        r;
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] last_idx;
        logic [IDX_W-1:0] idx_a;
        logic [IDX_W-1:0] idx_b;
        logic [ENT_W-1:0] moved;
        logic [ENT_W-1:0] ha;
        logic [ENT_W-1:0] hb;
        logic             live_a;
        logic [POS_W-1:0] pos_a_slot;
        r   = '0;
        idx = b.entity[IDX_W-1:0];
        case (b.op)
            OP_INSERT: begin
                if (slot_live[idx]) begin
                    r.error    = 1'b1;
                    r.position = slot_pos[idx];
                end else if (held >= CAPACITY) begin
                    r.error = 1'b1;
                end else begin
                    r.position           = POS_W'(held);
                    slot_live[idx]       = 1'b1;
                    slot_pos[idx]        = POS_W'(held);
                    packed_handles[held] = b.entity;
                    held++;
                end
            end
            OP_REMOVE: begin
                if (slot_live[idx] && held > 0) begin
                    // last entry fills the hole
                    r.position                   = slot_pos[idx];
                    moved                        = packed_handles[held-1];
                    last_idx                     = moved[IDX_W-1:0];
                    packed_handles[slot_pos[idx]] = moved;
                    slot_pos[last_idx]           = slot_pos[idx];
                    slot_live[last_idx]          = 1'b1;
                    slot_live[idx]               = 1'b0;
                    held--;
                end
            end
            OP_CONTAINS: begin
                if (slot_live[idx]) begin
                    r.found    = 1'b1;
                    r.position = slot_pos[idx];
                end
            end
            OP_CONTAINS_BEFORE: begin
                if (slot_live[idx]) begin
                    r.position = slot_pos[idx];
                    r.found    = (CNT_W'(slot_pos[idx]) < b.limit);
                end
            end
            OP_SWAP: begin
                if (int'(b.pos_a) >= held || int'(b.pos_b) >= held) begin
                    r.error = 1'b1;
                end else begin
                    ha                    = packed_handles[b.pos_a];
                    hb                    = packed_handles[b.pos_b];
                    idx_a                 = ha[IDX_W-1:0];
                    idx_b                 = hb[IDX_W-1:0];
                    live_a                = slot_live[idx_a];
                    pos_a_slot            = slot_pos[idx_a];
                    slot_live[idx_a]      = slot_live[idx_b];
                    slot_pos[idx_a]       = slot_pos[idx_b];
                    slot_live[idx_b]      = live_a;
                    slot_pos[idx_b]       = pos_a_slot;
                    packed_handles[b.pos_a] = hb;
                    packed_handles[b.pos_b] = ha;
                end
            end
            OP_CLEAR: begin
                for (int k = 0; k < held; k++) begin
                    ha                         = packed_handles[k];
                    slot_live[ha[IDX_W-1:0]] = 1'b0;
                end
                held = 0;
            end
            OP_READ_DENSE: begin
                if (int'(b.pos_a) >= held) r.error = 1'b1;
                else r.entity_out = packed_handles[b.pos_a];
            end
            default: begin
            end
        endcase
        r.count = CNT_W'(held);
        return r;
    endfunction

    // one table row
    task automatic add_row(input logic [OP_W-1:0] op, input logic [ENT_W-1:0] ent,
                           input int pa, input int pb, input int lim, input bit typed,
                           input bit f, input int pos, input logic [ENT_W-1:0] eout,
                           input int cnt, input bit err);
        stim_row_t row;
        row.beat   = '{op: op, entity: ent, pos_a: POS_W'(pa), pos_b: POS_W'(pb),
                       limit: CNT_W'(lim)};
        row.typed  = typed;
        row.result = '{found: f, position: POS_W'(pos), entity_out: eout,
                       count: CNT_W'(cnt), error: err};
        directed_rows.insert(directed_rows.size(), row);
    endtask

    // offer one beat, after a random idle spell unless steady, then log what it should return
    task automatic offer_beat(input in_beat_t b, input bit typed, input out_beat_t want);
        out_beat_t predicted;
        if (!steady) begin
            while ($urandom_range(0, 99) < 38) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_data  <= b;
        do @(posedge aclk); while (!s_ready);
        predicted = apply_set_op(b);
        pending_results.insert(pending_results.size(), typed ? want : predicted);
    endtask

    // result side: random back-pressure (none while steady) plus one long hold-off
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_ready <= steady || ($urandom_range(0, 99) >= 38);
            end
        end
    end

    task automatic report_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // result checker
    out_beat_t oldest;
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, actual %h",
                         $time, m_data);
                mismatches++;
            end else begin
                oldest = pending_results.pop_front();
                report_field("found", 32'(oldest.found), 32'(m_data.found));
                report_field("position", 32'(oldest.position), 32'(m_data.position));
                report_field("entity_out", 32'(oldest.entity_out), 32'(m_data.entity_out));
                report_field("count", 32'(oldest.count), 32'(m_data.count));
                report_field("error", 32'(oldest.error), 32'(m_data.error));
            end
        end
    end

    // stimulus
    int               pick;
    in_beat_t         b;
    logic [ENT_W-1:0] ent;
    initial begin
        for (int i = 0; i < MAP_DEPTH; i++) begin
            slot_live[i] = 1'b0;
            slot_pos[i]  = '0;
        end
        for (int i = 0; i < CAPACITY; i++) packed_handles[i] = '0;
        held = 0;

        // edge cases on an empty set, then a three-entry set
        add_row(OP_CONTAINS,        18'h00000, 0, 0, 0, 1, 0, 0, 0, 0, 0);
        add_row(OP_READ_DENSE,      18'h00000, 0, 0, 0, 1, 0, 0, 0, 0, 1);
        add_row(OP_SWAP,            18'h00000, 0, 0, 0, 1, 0, 0, 0, 0, 1);
        add_row(OP_REMOVE,          18'h00005, 0, 0, 0, 1, 0, 0, 0, 0, 0);
        add_row(OP_INSERT,          18'h3FFFF, 0, 0, 0, 1, 0, 0, 0, 1, 0);
        add_row(OP_INSERT,          18'h00000, 0, 0, 0, 1, 0, 1, 0, 2, 0);
        // same index, other generation: duplicate
        add_row(OP_INSERT,          18'h3FC00, 0, 0, 0, 1, 0, 1, 0, 2, 1);
        add_row(OP_INSERT,          18'h2A955, 0, 0, 0, 1, 0, 2, 0, 3, 0);
        add_row(OP_CONTAINS,        18'h003FF, 0, 0, 0, 1, 1, 0, 0, 3, 0);
        // member at the limit is not before it
        add_row(OP_CONTAINS_BEFORE, 18'h2A955, 0, 0, 2, 1, 0, 2, 0, 3, 0);
        add_row(OP_CONTAINS_BEFORE, 18'h2A955, 0, 0, 1024, 1, 1, 2, 0, 3, 0);
        add_row(OP_CONTAINS_BEFORE, 18'h00015, 0, 0, 1024, 1, 0, 0, 0, 3, 0);
        add_row(OP_READ_DENSE,      18'h00000, 1, 0, 0, 1, 0, 0, 18'h00000, 3, 0);
        add_row(OP_READ_DENSE,      18'h00000, 1023, 0, 0, 1, 0, 0, 0, 3, 1);
        add_row(OP_SWAP,            18'h00000, 0, 2, 0, 1, 0, 0, 0, 3, 0);
        add_row(OP_READ_DENSE,      18'h00000, 0, 0, 0, 1, 0, 0, 18'h2A955, 3, 0);
        add_row(OP_SWAP,            18'h00000, 1, 1023, 0, 1, 0, 0, 0, 3, 1);
        add_row(OP_SWAP,            18'h00000, 1023, 1, 0, 1, 0, 0, 0, 3, 1);
        add_row(OP_SWAP,            18'h00000, 1, 1, 0, 0, 0, 0, 0, 0, 0);
        // remove the tail, then remove the head so the tail moves down
        add_row(OP_REMOVE,          18'h003FF, 0, 0, 0, 1, 0, 2, 0, 2, 0);
        add_row(OP_REMOVE,          18'h2A955, 0, 0, 0, 1, 0, 0, 0, 1, 0);
        add_row(OP_CONTAINS,        18'h00000, 0, 0, 0, 1, 1, 0, 0, 1, 0);
        add_row(OP_UNUSED,          18'h3FFFF, 1023, 1023, 1024, 1, 0, 0, 0, 1, 0);
        add_row(OP_CLEAR,           18'h00000, 0, 0, 0, 1, 0, 0, 0, 0, 0);
        add_row(OP_CLEAR,           18'h00000, 0, 0, 0, 1, 0, 0, 0, 0, 0);

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i])
            offer_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].result);

        // random operations, mostly on a small set of indices
        for (int i = 0; i < RANDOM_BEATS; i++) begin
            steady = (i >= 200 && i < 300);
            if (i == 360) hold_request = 1'b1;
            b    = '0;
            pick = $urandom_range(0, 99);
            if (pick < 35)      b.op = OP_INSERT;
            else if (pick < 52) b.op = OP_REMOVE;
            else if (pick < 64) b.op = OP_CONTAINS;
            else if (pick < 75) b.op = OP_CONTAINS_BEFORE;
            else if (pick < 85) b.op = OP_SWAP;
            else if (pick < 95) b.op = OP_READ_DENSE;
            else if (pick < 98) b.op = OP_CLEAR;
            else                b.op = OP_UNUSED;
            pick = $urandom_range(0, 9);
            if (pick < 5 && held > 0) begin
                ent = packed_handles[$urandom_range(0, held - 1)];
                if ($urandom_range(0, 1)) ent[ENT_W-1:IDX_W] = GEN_W'($urandom);
            end else if (pick < 9) begin
                ent = {GEN_W'($urandom), IDX_W'($urandom_range(0, 47))};
            end else begin
                ent = ENT_W'($urandom);
            end
            b.entity = ent;
            if (held > 0 && $urandom_range(0, 3) != 0) begin
                b.pos_a = POS_W'($urandom_range(0, held - 1));
                b.pos_b = POS_W'($urandom_range(0, held - 1));
            end else begin
                b.pos_a = POS_W'($urandom);
                b.pos_b = POS_W'($urandom);
            end
            if ($urandom_range(0, 3) != 0) b.limit = CNT_W'($urandom_range(0, held + 1));
            else b.limit = CNT_W'($urandom_range(0, CAPACITY));
            offer_beat(b, 1'b0, '0);
        end
        steady = 1'b0;
        s_valid <= 1'b0;

        // drain
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("sparse_set_engine_unit test passed");
        end else begin
            $display("sparse_set_engine_unit test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
+incdir+rtl/core
rtl/core/sse_pkg.sv
rtl/core/sparse_set_engine_unit.sv
test/testbench.sv
